### sv/particle_simple_light_color_macros.svh
// Assertion macros shared by the particle light color RTL.
`ifndef PARTICLE_SIMPLE_LIGHT_COLOR_MACROS_SVH
`define PARTICLE_SIMPLE_LIGHT_COLOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property with reset masking.
`define PSLC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pslc assertion failed");
// Check a property at every edge, reset included.
`define PSLC_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("pslc assertion failed");
`else
`define PSLC_ASSERT(name, clk, rst_n, prop)
`define PSLC_ASSERT_NR(name, clk, prop)
`endif
`endif

### sv/pslc_pkg.sv
// Shared types, constants and step functions of the particle light color unit.
package pslc_pkg;

  localparam logic [1:0] ModeAmbient = 2'd1;
  localparam logic [1:0] ModeDiffuse = 2'd2;

  localparam logic [2:0] RegMode    = 3'd0;
  localparam logic [2:0] RegAmbient = 3'd1;
  localparam logic [2:0] RegDiffuse = 3'd2;
  localparam logic [2:0] RegRadius  = 3'd3;
  localparam logic [2:0] RegRowX    = 3'd4;
  localparam logic [2:0] RegRowY    = 3'd5;
  localparam logic [2:0] RegRowZ    = 3'd6;

  localparam int unsigned XformStages = 4;
  localparam int unsigned SqrtStages  = 16;
  localparam int unsigned DivStages   = 3;
  localparam int unsigned DivPerStage = 3;
  localparam int unsigned BlendStages = 2;
  localparam int unsigned Latency = XformStages + SqrtStages + DivStages + BlendStages;

  // Valid bit and the eight color bytes, primary red in the top byte.
  typedef struct packed {
    logic        vld;
    logic [63:0] col;
  } side_t;

  typedef struct packed {
    logic       blend;
    logic [8:0] attn;
  } light_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [8:0]  q;
  } div_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, logic [63:0] b);
    sqrt_t       o;
    logic [63:0] t;
    t = s.res + b;
    if (s.rem >= t) begin
      o.rem = s.rem - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One quotient bit; shift doubles the remainder first.
  function automatic div_t div_step(div_t s, logic [31:0] r, logic shift);
    div_t        o;
    logic [32:0] t;
    logic        ge;
    t  = shift ? {s.rem[31:0], 1'b0} : s.rem;
    ge = (t >= {1'b0, r});
    o.rem = ge ? (t - {1'b0, r}) : t;
    o.q   = {s.q[7:0], ge};
    return o;
  endfunction

endpackage

### sv/pslc_xform.sv
// Affine transform, saturation and sum of squares, four stages.
module pslc_xform #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pslc_pkg::side_t     side_i,
  input  logic signed [31:0]  pos_i [3],
  input  logic [63:0]         row_i [3],
  output pslc_pkg::side_t     side_o,
  output logic [63:0]         sq_o
);
  localparam int unsigned AccW  = 52;
  localparam int unsigned OffSh = 10 + FracBits;
  localparam int unsigned Sh    = FracBits - 2;
  localparam logic signed [AccW-1:0] SatHi = AccW'(64'sh7FFF_FFFF);
  localparam logic signed [AccW-1:0] SatLo = -AccW'(64'sh8000_0000);

  pslc_pkg::side_t side_q [4];
  logic signed [47:0] prod_d [9], prod_q [9];
  logic signed [31:0] crd_d [3], crd_q [3];
  logic [63:0]        sqr_d [3], sqr_q [3];
  logic [63:0]        sum_d, sum_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[3*r+c] = $signed(row_i[r][16*c +: 16]) * pos_i[c];
      end
    end
  end

  always_comb begin
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] off;
    for (int r = 0; r < 3; r++) begin
      off = $signed({{(AccW-16){row_i[r][63]}}, row_i[r][63:48]}) <<< OffSh;
      acc = AccW'(prod_q[3*r]) + AccW'(prod_q[3*r+1]) + AccW'(prod_q[3*r+2]) + off;
      acc = acc >>> Sh;
      if (acc > SatHi) begin
        crd_d[r] = 32'sh7FFF_FFFF;
      end else if (acc < SatLo) begin
        crd_d[r] = 32'sh8000_0000;
      end else begin
        crd_d[r] = acc[31:0];
      end
    end
  end

  always_comb begin
    logic [31:0] ab;
    for (int r = 0; r < 3; r++) begin
      ab = crd_q[r][31] ? (32'd0 - crd_q[r]) : crd_q[r];
      sqr_d[r] = 64'(ab) * 64'(ab);
    end
  end

  assign sum_d = sqr_q[0] + sqr_q[1] + sqr_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 4; s++) side_q[s].vld <= 1'b0;
    end else begin
      side_q[0] <= side_i;
      for (int s = 1; s < 4; s++) side_q[s] <= side_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    crd_q  <= crd_d;
    sqr_q  <= sqr_d;
    sum_q  <= sum_d;
  end

  assign side_o = side_q[3];
  assign sq_o   = sum_q;
endmodule

### sv/pslc_isqrt.sv
// Pipelined integer square root, two result bits per stage.
module pslc_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pslc_pkg::side_t side_i,
  input  logic [63:0]     sq_i,
  output pslc_pkg::side_t side_o,
  output logic [31:0]     dist_o
);
  localparam int unsigned N = pslc_pkg::SqrtStages;

  pslc_pkg::sqrt_t st_q [N];
  pslc_pkg::side_t sd_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam int unsigned ShA = 62 - 4*g;
    localparam int unsigned ShB = 60 - 4*g;
    pslc_pkg::sqrt_t s_in, s_mid, s_out;
    pslc_pkg::side_t sd_in;
    if (g == 0) begin : g_first
      assign s_in  = '{rem: sq_i, res: 64'd0};
      assign sd_in = side_i;
    end else begin : g_next
      assign s_in  = st_q[g-1];
      assign sd_in = sd_q[g-1];
    end
    assign s_mid = pslc_pkg::sqrt_step(s_in, 64'd1 << ShA);
    assign s_out = pslc_pkg::sqrt_step(s_mid, 64'd1 << ShB);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_q[g].vld <= 1'b0;
      end else begin
        sd_q[g] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[g] <= s_out;
    end
  end

  assign side_o = sd_q[N-1];
  assign dist_o = st_q[N-1].res[31:0];
endmodule

### sv/pslc_div.sv
// Attenuation divider, three quotient bits per stage, and blend select.
module pslc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pslc_pkg::side_t  side_i,
  input  logic [31:0]      dist_i,
  input  logic [31:0]      radius_i,
  input  logic [1:0]       mode_i,
  output pslc_pkg::side_t  side_o,
  output pslc_pkg::light_t light_o
);
  localparam int unsigned N = pslc_pkg::DivStages;
  localparam int unsigned P = pslc_pkg::DivPerStage;

  pslc_pkg::div_t  dv_q [N];
  pslc_pkg::side_t sd_q [N];
  logic            bl_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    pslc_pkg::div_t  d_in;
    pslc_pkg::div_t  d_out;
    pslc_pkg::side_t sd_in;
    logic            bl_in;
    if (g == 0) begin : g_first
      assign d_in  = '{rem: {1'b0, dist_i}, q: 9'd0};
      assign sd_in = side_i;
      assign bl_in = (mode_i == pslc_pkg::ModeDiffuse) && (radius_i != 32'd0)
                     && (dist_i <= radius_i);
    end else begin : g_next
      assign d_in  = dv_q[g-1];
      assign sd_in = sd_q[g-1];
      assign bl_in = bl_q[g-1];
    end

    always_comb begin
      pslc_pkg::div_t t;
      t = d_in;
      for (int j = 0; j < P; j++) begin
        t = pslc_pkg::div_step(t, radius_i, (g*P + j) != 0);
      end
      d_out = t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_q[g].vld <= 1'b0;
      end else begin
        sd_q[g] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[g] <= d_out;
      bl_q[g] <= bl_in;
    end
  end

  assign side_o        = sd_q[N-1];
  assign light_o.blend = bl_q[N-1];
  assign light_o.attn  = dv_q[N-1].q;
endmodule

### sv/pslc_blend.sv
// Per channel light factor and final color scaling, two stages.
module pslc_blend (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pslc_pkg::side_t  side_i,
  input  pslc_pkg::light_t light_i,
  input  logic [1:0]       mode_i,
  input  logic [31:0]      ambient_i,
  input  logic [31:0]      diffuse_i,
  output logic             vld_o,
  output logic [63:0]      col_o
);
  pslc_pkg::side_t side_q;
  logic [16:0]     fac_d [4], fac_q [4];
  logic            bl_q;
  logic [63:0]     col_d, col_q;
  logic            vld_q;

  always_comb begin
    logic [7:0]  a, d;
    logic [17:0] l;
    for (int k = 0; k < 4; k++) begin
      a = ambient_i[31-8*k -: 8];
      d = diffuse_i[31-8*k -: 8];
      l = {2'b0, d, 8'b0} + 18'(light_i.attn * a) - 18'(light_i.attn * d);
      if (mode_i inside {pslc_pkg::ModeAmbient, pslc_pkg::ModeDiffuse}) begin
        fac_d[k] = light_i.blend ? l[16:0] : {1'b0, a, 8'b0};
      end else begin
        fac_d[k] = 17'h1_0000;
      end
    end
  end

  // Ambient and pass-through factors carry eight extra fraction bits, so round at bit 15.
  always_comb begin
    logic [7:0]  c;
    logic [24:0] p;
    for (int i = 0; i < 8; i++) begin
      c = side_q.col[63-8*i -: 8];
      p = 25'(c * fac_q[i % 4]) + (bl_q ? 25'd128 : 25'd32768);
      col_d[63-8*i -: 8] = p[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q.vld <= 1'b0;
      vld_q      <= 1'b0;
    end else begin
      side_q <= side_i;
      vld_q  <= side_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    fac_q <= fac_d;
    bl_q  <= light_i.blend;
    col_q <= col_d;
  end

  assign vld_o = vld_q;
  assign col_o = col_q;
endmodule

### sv/particle_simple_light_color.sv
// Particle light color unit: lights a primary and a secondary RGBA color per particle.
// The pipeline has 4 transform, 16 root, 3 divide and 2 blend stages; throughput is one word
//   per cycle, busy is never raised.
// The receiver cannot stall; valid_o marks each result for exactly one cycle.
// Reset clears every valid bit and loads the register defaults; no clearing pass.
`include "particle_simple_light_color_macros.svh"
module particle_simple_light_color #(
  parameter int unsigned POS_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [7:0]  pri_red_i,
  input  logic [7:0]  pri_green_i,
  input  logic [7:0]  pri_blue_i,
  input  logic [7:0]  pri_alpha_i,
  input  logic [7:0]  sec_red_i,
  input  logic [7:0]  sec_green_i,
  input  logic [7:0]  sec_blue_i,
  input  logic [7:0]  sec_alpha_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        valid_o,
  output logic [7:0]  lit_pri_red_o,
  output logic [7:0]  lit_pri_green_o,
  output logic [7:0]  lit_pri_blue_o,
  output logic [7:0]  lit_pri_alpha_o,
  output logic [7:0]  lit_sec_red_o,
  output logic [7:0]  lit_sec_green_o,
  output logic [7:0]  lit_sec_blue_o,
  output logic [7:0]  lit_sec_alpha_o
);
  localparam int unsigned Lat = pslc_pkg::Latency;

  // Configuration registers; the user must write them only while the pipe is empty, the block does not enforce it.
  logic [1:0]  mode_q;
  logic [31:0] amb_q, dif_q, rad_q;
  logic [63:0] row_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd0;
      amb_q    <= 32'hFFFF_FFFF;
      dif_q    <= 32'hFFFF_FFFF;
      rad_q    <= 32'd0;
      row_q[0] <= 64'h0000_0000_0000_4000;
      row_q[1] <= 64'h0000_0000_4000_0000;
      row_q[2] <= 64'h0000_4000_0000_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pslc_pkg::RegMode:    mode_q   <= cfg_wdata_i[1:0];
        pslc_pkg::RegAmbient: amb_q    <= cfg_wdata_i[31:0];
        pslc_pkg::RegDiffuse: dif_q    <= cfg_wdata_i[31:0];
        pslc_pkg::RegRadius:  rad_q    <= cfg_wdata_i[31:0];
        pslc_pkg::RegRowX:    row_q[0] <= cfg_wdata_i;
        pslc_pkg::RegRowY:    row_q[1] <= cfg_wdata_i;
        pslc_pkg::RegRowZ:    row_q[2] <= cfg_wdata_i;
        default: ;  // drop writes past the last register
      endcase
    end
  end

  // The pipe never stalls, so a word is taken every cycle start is high.
  assign busy = 1'b0;

  pslc_pkg::side_t  side_in, side_x, side_s, side_d;
  pslc_pkg::light_t light_d;
  logic signed [31:0] pos [3];
  logic [63:0] sq;
  logic [31:0] dist_len;
  logic [63:0] col_out;

  assign side_in.vld = start & ~busy;
  assign side_in.col = {pri_red_i, pri_green_i, pri_blue_i, pri_alpha_i,
                        sec_red_i, sec_green_i, sec_blue_i, sec_alpha_i};
  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  // Move into light space and form the squared distance.
  pslc_xform #(.FracBits(POS_FRAC_BITS)) u_xform (
    .clk_i, .rst_ni, .side_i(side_in), .pos_i(pos), .row_i(row_q),
    .side_o(side_x), .sq_o(sq)
  );

  // Take the floor square root to get the Q16.16 distance.
  pslc_isqrt u_isqrt (
    .clk_i, .rst_ni, .side_i(side_x), .sq_i(sq), .side_o(side_s), .dist_o(dist_len)
  );

  // Scale distance against the radius and decide blend versus ambient.
  pslc_div u_div (
    .clk_i, .rst_ni, .side_i(side_s), .dist_i(dist_len), .radius_i(rad_q),
    .mode_i(mode_q), .side_o(side_d), .light_o(light_d)
  );

  // Build per channel factors and scale both colors.
  pslc_blend u_blend (
    .clk_i, .rst_ni, .side_i(side_d), .light_i(light_d), .mode_i(mode_q),
    .ambient_i(amb_q), .diffuse_i(dif_q), .vld_o(valid_o), .col_o(col_out)
  );

  assign lit_pri_red_o   = col_out[63:56];
  assign lit_pri_green_o = col_out[55:48];
  assign lit_pri_blue_o  = col_out[47:40];
  assign lit_pri_alpha_o = col_out[39:32];
  assign lit_sec_red_o   = col_out[31:24];
  assign lit_sec_green_o = col_out[23:16];
  assign lit_sec_blue_o  = col_out[15:8];
  assign lit_sec_alpha_o = col_out[7:0];

  // Every accepted word comes out on valid_o after the full pipeline, and nothing else does.
  `PSLC_ASSERT(a_lat_fwd, clk_i, rst_ni, (start && !busy) |-> ##Lat valid_o)
  `PSLC_ASSERT(a_lat_back, clk_i, rst_ni, valid_o |-> $past(start && !busy, Lat))
  // A blended word never carries attenuation above full scale.
  `PSLC_ASSERT(a_attn, clk_i, rst_ni, (side_d.vld && light_d.blend) |-> (light_d.attn <= 9'd256))
endmodule
